/* rtl/core/assert_macros.svh */
// Assertion macros shared by the timer bank modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define ECT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk edge outside reset.
`define ECT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ect_pkg.sv */
// Shared types and codes for the event countdown timer bank.
package ect_pkg;

  // Operation codes carried by each input item.
  typedef enum logic [1:0] {
    OP_ARM   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Controller state: result register empty or holding an item.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } ect_cmd_t;

  // Width of the pending-event word.
  localparam int unsigned FlagBits = 8;

endpackage

/* rtl/core/ect_dp.sv */
// Datapath: countdown registers, event flags and per-item update logic.
`include "assert_macros.svh"

module ect_dp #(
  parameter int unsigned NUM_EVENTS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ect_pkg::ect_cmd_t               cmd,
  input  logic [1:0]                      operation,
  input  logic [ect_pkg::FlagBits-1:0]    event_mask,
  input  logic [31:0]                     timeout_ticks,
  output logic [ect_pkg::FlagBits-1:0]    pending_events
);

  localparam logic [ect_pkg::FlagBits-1:0] SlotMask =
    ect_pkg::FlagBits'((16'd1 << NUM_EVENTS) - 16'd1);
  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [COUNT_BITS-1:0]        countdown      [NUM_EVENTS];
  logic [COUNT_BITS-1:0]        countdown_next [NUM_EVENTS];
  logic [ect_pkg::FlagBits-1:0] flags;
  logic [ect_pkg::FlagBits-1:0] flags_next;
  logic [ect_pkg::FlagBits-1:0] sel;
  logic                         single_slot;
  logic [COUNT_BITS-1:0]        load_val;
  logic                         fire0;

  always_comb begin
    sel         = event_mask & SlotMask;
    single_slot = (sel != '0) && ((sel & (sel - 1'b1)) == '0);
    // Saturate timeouts that do not fit a counter.
    load_val    = (timeout_ticks > CountMax) ? CountMax[COUNT_BITS-1:0]
                                             : timeout_ticks[COUNT_BITS-1:0];
    flags_next  = flags;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      countdown_next[i] = countdown[i];
    end
    unique case (ect_pkg::op_t'(operation))
      ect_pkg::OP_ARM: begin
        flags_next = flags & ~sel;
        if ((timeout_ticks != '0) && single_slot) begin
          for (int i = 0; i < NUM_EVENTS; i++) begin
            if (sel[i]) countdown_next[i] = load_val;
          end
        end
      end
      ect_pkg::OP_SET: begin
        flags_next = flags | sel;
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if (sel[i]) countdown_next[i] = '0;
        end
      end
      ect_pkg::OP_CLEAR: begin
        flags_next = flags & ~sel;
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if (sel[i]) countdown_next[i] = '0;
        end
      end
      ect_pkg::OP_TICK: begin
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if (countdown[i] != '0) begin
            countdown_next[i] = countdown[i] - COUNT_BITS'(1);
            if (countdown[i] == COUNT_BITS'(1)) flags_next[i] = 1'b1;
          end
        end
      end
    endcase
    fire0 = cmd.exec && (ect_pkg::op_t'(operation) == ect_pkg::OP_TICK) &&
            (countdown[0] == COUNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        countdown[i] <= '0;
      end
    end else if (cmd.exec) begin
      flags <= flags_next & SlotMask;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        countdown[i] <= countdown_next[i];
      end
    end
  end

  assign pending_events = flags;

  `ECT_ASSERT_NOW(a_no_phantom_slots, 1'b1, (flags & ~SlotMask) == '0, "flag beyond slot count")
  `ECT_ASSERT_NEXT(a_tick_fires, fire0, flags[0], "slot 0 expired without raising its flag")

endmodule

/* rtl/core/ect_ctrl.sv */
// Controller: handshake state machine that issues one execute per item.
`include "assert_macros.svh"

module ect_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ect_pkg::ect_cmd_t cmd
);

  ect_pkg::state_t state;
  ect_pkg::state_t state_next;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ect_pkg::ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    out_valid = (state == ect_pkg::ST_FULL);
    // Take a new item whenever the result slot is free or drains this cycle.
    in_stall  = out_valid && out_stall;
    accept    = in_valid && !in_stall;
    cmd.exec  = accept;
    state_next = state;
    unique case (state)
      ect_pkg::ST_EMPTY: begin
        if (accept) state_next = ect_pkg::ST_FULL;
      end
      ect_pkg::ST_FULL: begin
        if (!out_stall && !accept) state_next = ect_pkg::ST_EMPTY;
      end
    endcase
  end

  `ECT_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted item left no result")
  `ECT_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid, "input stalled with empty result")
  `ECT_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !in_valid, !out_valid,
                   "result repeated after being taken")

endmodule

/* rtl/core/event_countdown_timer_bank.sv */
// Event countdown timer bank: eight countdown slots and a pending-event word.
// Latency: the result of an item is presented on the cycle after it is accepted.
// Throughput: one item per cycle while the result is not stalled; all slot counters update in parallel.
// The single result register is refilled in the cycle it is taken, so no bubble.
// Reset (rst, synchronous): all counters idle at zero, all flags clear, no result.
// Counters and flags are flip-flops, so no clearing pass follows reset.
module event_countdown_timer_bank #(
  parameter int unsigned NUM_EVENTS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  event_mask,
  input  logic [31:0] timeout_ticks,
  // Result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pending_events
);

  // Execute strobe: one per accepted item.
  ect_pkg::ect_cmd_t cmd;

  // Handshake control: the pending word is the result register itself,
  // held steady while the downstream side stalls.
  ect_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Counters and flags; arm/set/clear/tick decoded from the item.
  ect_dp #(
    .NUM_EVENTS (NUM_EVENTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (operation),
    .event_mask     (event_mask),
    .timeout_ticks  (timeout_ticks),
    .pending_events (pending_events)
  );

endmodule
